// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BFA_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BFA_ASSERT(lbl, clk, rstn, prop, msg)
`define BFA_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- rtl/core/bfa_pkg.sv -----
// shared constants, codes and types of the best-fit allocator
`timescale 1ns / 1ps
package bfa_pkg;
	localparam int PAGES        = 4;
	localparam int PAGE_BYTES   = 4096;
	localparam int UNIT_BYTES   = 8;
	localparam int BLK_PER_PAGE = PAGE_BYTES / UNIT_BYTES;
	localparam int TOTAL_BLKS   = PAGES * BLK_PER_PAGE;
	localparam int PAGE_W       = $clog2(PAGES);
	localparam int BOFF_W       = $clog2(BLK_PER_PAGE);
	localparam int ADDR_W       = PAGE_W + BOFF_W;
	localparam int LEN_W        = BOFF_W + 1;
	localparam int UNIT_SH      = $clog2(UNIT_BYTES);

	// port field widths
	localparam int CMD_W   = 2;
	localparam int BYTES_W = 13;
	localparam int PNUM_W  = 2;
	localparam int OFF_W   = 12;
	localparam int STAT_W  = 2;

	// commands
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_SIZE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd3;

	// one scanned block handed to the run tracker
	typedef struct packed {
		logic              clr;
		logic              vld;
		logic [ADDR_W-1:0] idx;
		logic              free_bit;
	} scan_in_t;

	// best run found so far
	typedef struct packed {
		logic              found;
		logic [PAGE_W-1:0] page;
		logic [BOFF_W-1:0] off;
	} best_t;
endpackage

// ----- rtl/core/best_fit_bitmap_allocator.sv -----
// top level of the best-fit bitmap allocator
// alloc scans the free map, picks a run and marks it block by block; free reads the
// length, frees block by block; clear sweeps; bad size and unused commands end in idle
// throughput: one item at a time, busy until its result strobe; the alloc scan reads
// one free bit per cycle from the single read port of the free map
// reset: a clearing pass over every entry of both memories runs after arst_n, busy high
// results are strobed on done for one cycle and cannot be held off
`timescale 1ns / 1ps
`include "assert_macros.svh"
module best_fit_bitmap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bfa_pkg::CMD_W-1:0]   command,
	input  logic [bfa_pkg::BYTES_W-1:0] request_bytes,
	input  logic [bfa_pkg::PNUM_W-1:0]  page_number,
	input  logic [bfa_pkg::OFF_W-1:0]   byte_offset,
	output logic                        done,
	output logic [bfa_pkg::STAT_W-1:0]  status,
	output logic [bfa_pkg::PNUM_W-1:0]  out_page,
	output logic [bfa_pkg::OFF_W-1:0]   out_offset
);
	import bfa_pkg::*;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_FLOOK, S_FCHK, S_FREL, S_SCAN, S_PICK, S_MARK
	} state_t;

	state_t            state_q;
	logic [ADDR_W:0]   cnt_q;
	logic [ADDR_W-1:0] addr_q, base_q;
	logic [LEN_W-1:0]  rem_q, req_q;
	logic [PAGES-1:0]  page_open_q;
	logic              clr_reply_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [PNUM_W-1:0] out_page_q;
	logic [OFF_W-1:0]  out_offset_q;
	logic              scan_v_s1;
	logic [ADDR_W-1:0] scan_idx_s1;

	logic              fm_we, fm_wdata, fm_re, fm_rdata;
	logic [ADDR_W-1:0] fm_waddr, fm_raddr;
	logic              ln_we, ln_re;
	logic [ADDR_W-1:0] ln_waddr, ln_raddr;
	logic [LEN_W-1:0]  ln_wdata, ln_rdata;

	scan_in_t          sin;
	best_t             best;
	logic              rel_last;
	logic              free_pg_ok;
	logic [PAGE_W-1:0] free_pg;

	// memory port control
	always_comb begin
		fm_we    = (state_q == S_INIT) || (state_q == S_MARK) || (state_q == S_FREL);
		fm_waddr = (state_q == S_INIT) ? cnt_q[ADDR_W-1:0] : addr_q;
		fm_wdata = (state_q != S_MARK);
		fm_re    = (state_q == S_SCAN) && !cnt_q[ADDR_W];
		fm_raddr = cnt_q[ADDR_W-1:0];
		rel_last = (rem_q == LEN_W'(1)) || (addr_q[BOFF_W-1:0] == '1);
		ln_we    = (state_q == S_INIT) || ((state_q == S_MARK) && (rem_q == LEN_W'(1))) ||
			((state_q == S_FREL) && rel_last);
		ln_waddr = (state_q == S_INIT) ? cnt_q[ADDR_W-1:0] : base_q;
		ln_wdata = (state_q == S_MARK) ? req_q : '0;
		ln_re    = (state_q == S_FLOOK);
		ln_raddr = base_q;
	end

	// lowest unopened page
	always_comb begin
		free_pg_ok = 1'b0;
		free_pg    = '0;
		for (int i = PAGES - 1; i >= 0; i--) begin
			if (!page_open_q[i]) begin
				free_pg_ok = 1'b1;
				free_pg    = PAGE_W'(i);
			end
		end
	end

	bfa_ram #(.WIDTH(1), .DEPTH(TOTAL_BLKS)) u_free_map (
		.clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
		.re(fm_re), .raddr(fm_raddr), .rdata(fm_rdata)
	);

	bfa_ram #(.WIDTH(LEN_W), .DEPTH(TOTAL_BLKS)) u_alloc_len (
		.clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
		.re(ln_re), .raddr(ln_raddr), .rdata(ln_rdata)
	);

	// run tracker input
	always_comb begin
		sin.clr      = (state_q == S_IDLE);
		sin.vld      = scan_v_s1;
		sin.idx      = scan_idx_s1;
		sin.free_bit = fm_rdata;
	end

	bfa_scan u_scan (
		.clk(clk), .arst_n(arst_n), .sin(sin), .page_open(page_open_q),
		.req(req_q), .best(best)
	);

	// scan read pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1   <= 1'b0;
			scan_idx_s1 <= '0;
		end else begin
			scan_v_s1   <= fm_re;
			scan_idx_s1 <= fm_raddr;
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			addr_q       <= '0;
			base_q       <= '0;
			rem_q        <= '0;
			req_q        <= '0;
			page_open_q  <= '0;
			clr_reply_q  <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= STAT_OK;
			out_page_q   <= '0;
			out_offset_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[ADDR_W-1:0] == '1) begin
						state_q <= S_IDLE;
						if (clr_reply_q) begin
							done_q       <= 1'b1;
							status_q     <= STAT_OK;
							out_page_q   <= '0;
							out_offset_q <= '0;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						status_q     <= STAT_OK;
						out_page_q   <= '0;
						out_offset_q <= '0;
						case (command)
							CMD_ALLOC: begin
								if ((request_bytes == '0) ||
									((request_bytes & BYTES_W'(UNIT_BYTES - 1)) != '0)) begin
									status_q <= STAT_BAD_SIZE;
									done_q   <= 1'b1;
								end else if (32'(request_bytes >> UNIT_SH) > BLK_PER_PAGE) begin
									status_q <= STAT_NO_SPACE;
									done_q   <= 1'b1;
								end else begin
									req_q   <= LEN_W'(request_bytes >> UNIT_SH);
									cnt_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							CMD_FREE: begin
								if ((32'(page_number) >= PAGES) ||
									(32'(byte_offset) >= PAGE_BYTES) ||
									((byte_offset & OFF_W'(UNIT_BYTES - 1)) != '0)) begin
									status_q <= STAT_BAD_ADDR;
									done_q   <= 1'b1;
								end else begin
									base_q  <= {PAGE_W'(page_number), BOFF_W'(byte_offset >> UNIT_SH)};
									state_q <= S_FLOOK;
								end
							end
							CMD_CLEAR: begin
								cnt_q       <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= S_INIT;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_FLOOK: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (ln_rdata == '0) begin
						status_q <= STAT_BAD_ADDR;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						rem_q   <= ln_rdata;
						addr_q  <= base_q;
						state_q <= S_FREL;
					end
				end
				S_FREL: begin
					addr_q <= addr_q + 1'b1;
					rem_q  <= rem_q - 1'b1;
					if (rel_last) begin
						status_q <= STAT_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (!cnt_q[ADDR_W]) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!scan_v_s1) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					rem_q <= req_q;
					if (best.found) begin
						addr_q  <= {best.page, best.off};
						base_q  <= {best.page, best.off};
						state_q <= S_MARK;
					end else if (free_pg_ok) begin
						page_open_q[free_pg] <= 1'b1;
						addr_q  <= {free_pg, BOFF_W'(0)};
						base_q  <= {free_pg, BOFF_W'(0)};
						state_q <= S_MARK;
					end else begin
						status_q <= STAT_NO_SPACE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_MARK: begin
					addr_q <= addr_q + 1'b1;
					rem_q  <= rem_q - 1'b1;
					if (rem_q == LEN_W'(1)) begin
						status_q     <= STAT_OK;
						out_page_q   <= PNUM_W'(base_q[ADDR_W-1:BOFF_W]);
						out_offset_q <= OFF_W'({base_q[BOFF_W-1:0], UNIT_SH'(0)});
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign out_page   = out_page_q;
	assign out_offset = out_offset_q;

	// checks
	`BFA_ASSERT(a_done_has_item, clk, arst_n, done |-> ($past(start && !busy) || $past(busy)), "result without an item")
	`BFA_ASSERT(a_fail_zero, clk, arst_n, (done && (status != STAT_OK)) |-> ((out_page == '0) && (out_offset == '0)), "failed result carries a place")
	`BFA_ASSERT(a_clear_busy, clk, arst_n, (start && !busy && (command == CMD_CLEAR)) |=> busy, "clear did not start a sweep")
	`BFA_NEVER(a_scan_outside, clk, arst_n, scan_v_s1 && (state_q != S_SCAN), "scan data outside the scan")
endmodule

// ----- rtl/core/bfa_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module bfa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/bfa_scan.sv -----
// free run tracker: follows runs block by block and keeps the best fit
`timescale 1ns / 1ps
module bfa_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bfa_pkg::scan_in_t          sin,
	input  logic [bfa_pkg::PAGES-1:0]  page_open,
	input  logic [bfa_pkg::LEN_W-1:0]  req,
	output bfa_pkg::best_t             best
);
	import bfa_pkg::*;

	logic [LEN_W-1:0]  run_q;
	logic [BOFF_W-1:0] start_q;
	logic [LEN_W-1:0]  best_len_q;
	best_t             best_q;

	logic [PAGE_W-1:0] pg;
	logic [BOFF_W-1:0] blk;
	logic              opn, cur_free, last_b, close, take;
	logic [LEN_W-1:0]  nrun, clen;
	logic [BOFF_W-1:0] nstart, cst;

	// run bookkeeping for the block now read
	always_comb begin
		pg       = sin.idx[ADDR_W-1:BOFF_W];
		blk      = sin.idx[BOFF_W-1:0];
		opn      = page_open[pg];
		cur_free = sin.free_bit & opn;
		nrun     = run_q + 1'b1;
		nstart   = (run_q == '0) ? blk : start_q;
		last_b   = (blk == BOFF_W'(BLK_PER_PAGE - 1));
		clen     = cur_free ? nrun : run_q;
		cst      = cur_free ? nstart : start_q;
		close    = opn & (~cur_free | last_b);
		take     = close && (clen != '0) && (clen >= req) &&
			(!best_q.found || (best_len_q >= clen));
	end

	// run and best registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			start_q    <= '0;
			best_len_q <= '0;
			best_q     <= '0;
		end else if (sin.clr) begin
			run_q        <= '0;
			best_q.found <= 1'b0;
		end else if (sin.vld) begin
			run_q   <= close ? '0 : (cur_free ? nrun : run_q);
			start_q <= cst;
			if (take) begin
				best_q.found <= 1'b1;
				best_q.page  <= pg;
				best_q.off   <= cst;
				best_len_q   <= clen;
			end
		end
	end

	assign best = best_q;
endmodule
